>>> hw/rtl/sfms_pkg.sv
`timescale 1ns / 1ps

package sfms_pkg;

    // Field widths fixed by the interface.
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 16;

    // Item kinds on the input channel.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_APPEND = 2'd0;
    localparam kind_t KIND_TEXT   = 2'd1;
    localparam kind_t KIND_CLEAR  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // input transaction taken this cycle
        logic cmp_step;    // compare sequence is running
        logic cmp_finish;  // compare sequence ends this cycle
        logic load_out;    // move the pending result into the output register
    } sfms_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic acc_cmp;      // accepted text byte needs a window compare
        logic acc_emit;     // accepted text byte gives a result directly
        logic cmp_done;     // all pattern bytes have been checked
        logic emit_needed;  // finished compare gives a result
        logic out_free;     // output register can take a result
    } sfms_status_t;

endpackage

>>> hw/rtl/substring_first_match_search.sv
`timescale 1ns / 1ps
// Appends, clears, ignored kinds and text bytes with no compare and no result leave s_ready high.
// A text byte that gives a result without a compare holds the input in ST_EMIT until its result
// is loaded into the output register. A text byte that needs a window compare holds the input
// through ST_CMP, then through ST_EMIT when it gives a result, reading one stored
// pattern byte per cycle in ST_CMP. Its result waits in ST_EMIT while m_ready stalls the output.
// aresetn is synchronous, active low, and empties the pattern and ends any search.

module substring_first_match_search
    import sfms_pkg::*;
#(
    parameter int PATTERN_MAX = 64,
    parameter int TEXT_MAX    = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic [7:0]          s_byte_value,
    input  logic                s_last,
    input  logic [15:0]         s_start_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [15:0]         m_match_index,
    output logic                m_pattern_overflow
);

    sfms_cmd_t    cmd;
    sfms_status_t status;

    // Sequencing of transactions and compare steps.
    sfms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Pattern store, text window, compare and output register.
    sfms_dp #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_kind             (kind_t'(s_kind)),
        .s_byte_value       (s_byte_value),
        .s_last             (s_last),
        .s_start_index      (s_start_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_found            (m_found),
        .m_match_index      (m_match_index),
        .m_pattern_overflow (m_pattern_overflow)
    );

endmodule

>>> hw/rtl/sfms_ctrl.sv
`timescale 1ns / 1ps

module sfms_ctrl
    import sfms_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  sfms_status_t status,
    output sfms_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // New transactions are taken only while no search step is in flight.
    assign s_ready        = (state_reg == ST_IDLE);
    assign cmd.accept     = s_valid && (state_reg == ST_IDLE);
    assign cmd.cmp_step   = (state_reg == ST_CMP);
    assign cmd.cmp_finish = (state_reg == ST_CMP) && status.cmp_done;
    assign cmd.load_out   = (state_reg == ST_EMIT) && status.out_free;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    if (status.acc_cmp) begin
                        state_next = ST_CMP;
                    end else if (status.acc_emit) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CMP: begin
                if (status.cmp_done) begin
                    state_next = status.emit_needed ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/sfms_dp.sv
`timescale 1ns / 1ps

module sfms_dp
    import sfms_pkg::*;
#(
    parameter int PATTERN_MAX = 64,
    parameter int TEXT_MAX    = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sfms_cmd_t           cmd,
    output sfms_status_t        status,
    input  kind_t               s_kind,
    input  logic [BYTE_W-1:0]   s_byte_value,
    input  logic                s_last,
    input  logic [INDEX_W-1:0]  s_start_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [INDEX_W-1:0]  m_match_index,
    output logic                m_pattern_overflow
);

    localparam int PAW       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CW        = $clog2(PATTERN_MAX + 1);
    localparam int WAW       = PAW;
    localparam int WIN_DEPTH = 1 << WAW;
    localparam int POSW      = $clog2(TEXT_MAX + 1);
    localparam int SW0       = (POSW > CW) ? POSW : CW;
    localparam int SW        = (SW0 > INDEX_W) ? SW0 : INDEX_W;

    // Pattern store and circular text window.
    logic [BYTE_W-1:0] pattern_mem [PATTERN_MAX];
    logic [BYTE_W-1:0] window_mem [WIN_DEPTH];

    // Control registers.
    logic [CW-1:0]      count_reg, count_next;
    logic               overflow_reg, overflow_next;
    logic [POSW-1:0]    pos_reg, pos_next;
    logic [INDEX_W-1:0] start_reg, start_next;
    logic               done_reg, done_next;
    logic [WAW-1:0]     wptr_reg, wptr_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic               mismatch_reg, mismatch_next;
    logic               m_valid_reg, m_valid_next;

    // Payload registers.
    logic [WAW-1:0]     base_reg, base_next;
    logic               last_reg, last_next;
    logic               res_found_reg, res_found_next;
    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    logic [BYTE_W-1:0]  pat_rd_reg;
    logic [BYTE_W-1:0]  win_rd_reg;
    logic               m_found_reg;
    logic [INDEX_W-1:0] m_index_reg;
    logic               m_overflow_reg;

    // Decode of the accepted transaction.
    logic               is_append;
    logic               is_text;
    logic               is_clear;
    logic               pos_first;
    logic [INDEX_W-1:0] start_eff;
    logic               in_range;
    logic [SW-1:0]      pos_inc_ext;
    logic [SW-1:0]      cnt_ext;
    logic [SW-1:0]      cand_ext;
    logic               cmp_need;
    logic               empty_hit;
    logic               room;
    logic               issue;

    assign is_append = cmd.accept && (s_kind == KIND_APPEND);
    assign is_text   = cmd.accept && (s_kind == KIND_TEXT);
    assign is_clear  = cmd.accept && (s_kind == KIND_CLEAR);
    assign room      = (count_reg < CW'(PATTERN_MAX));

    // Candidate match start for the newest byte and its qualification.
    assign pos_first   = (pos_reg == '0);
    assign start_eff   = pos_first ? s_start_index : start_reg;
    assign in_range    = (SW'(pos_reg) < SW'(TEXT_MAX));
    assign pos_inc_ext = SW'(pos_reg) + SW'(1);
    assign cnt_ext     = SW'(count_reg);
    assign cand_ext    = pos_inc_ext - cnt_ext;
    assign cmp_need    = in_range && !done_reg && (count_reg != '0) &&
                         (pos_inc_ext >= cnt_ext) && (cand_ext >= SW'(start_eff));
    assign empty_hit   = in_range && !done_reg && (count_reg == '0) && pos_first;

    // One pattern byte is read per cycle during a compare.
    assign issue = cmd.cmp_step && (idx_reg < count_reg);

    assign status.acc_cmp     = is_text && cmp_need;
    assign status.acc_emit    = is_text && (empty_hit || (s_last && !done_reg && !cmp_need));
    assign status.cmp_done    = (idx_reg == count_reg) && !chk_valid_reg;
    assign status.emit_needed = !mismatch_reg || last_reg;
    assign status.out_free    = !m_valid_reg || m_ready;

    // Next-value logic for the search state.
    always_comb begin
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        done_next      = done_reg;
        wptr_next      = wptr_reg;
        idx_next       = idx_reg;
        chk_valid_next = issue;
        mismatch_next  = mismatch_reg;
        base_next      = base_reg;
        last_next      = last_reg;
        res_found_next = res_found_reg;
        res_index_next = res_index_reg;
        m_valid_next   = m_valid_reg;

        // Pattern maintenance.
        if (is_append) begin
            if (room) begin
                count_next = count_reg + CW'(1);
            end else begin
                overflow_next = 1'b1;
            end
        end
        if (is_clear) begin
            count_next    = '0;
            overflow_next = 1'b0;
        end

        // Text byte: shift into the window and set up any compare.
        if (is_text) begin
            last_next      = s_last;
            base_next      = wptr_reg - WAW'(count_reg) + WAW'(1);
            idx_next       = '0;
            mismatch_next  = 1'b0;
            res_found_next = empty_hit;
            res_index_next = cmp_need ? cand_ext[INDEX_W-1:0] : '0;
            if (pos_first) begin
                start_next = s_start_index;
            end
            if (in_range) begin
                wptr_next = wptr_reg + WAW'(1);
                pos_next  = POSW'(pos_inc_ext);
            end
            if (empty_hit) begin
                done_next = 1'b1;
            end
            if (s_last && !cmp_need) begin
                pos_next   = '0;
                start_next = '0;
                done_next  = 1'b0;
                wptr_next  = '0;
            end
        end

        // Compare sequence.
        if (issue) begin
            idx_next = idx_reg + CW'(1);
        end
        if (chk_valid_reg && (pat_rd_reg != win_rd_reg)) begin
            mismatch_next = 1'b1;
        end
        if (cmd.cmp_finish) begin
            res_found_next = !mismatch_reg;
            if (!mismatch_reg) begin
                done_next = 1'b1;
            end
            if (last_reg) begin
                pos_next   = '0;
                start_next = '0;
                done_next  = 1'b0;
                wptr_next  = '0;
            end
        end

        // Output register handshake.
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            pos_reg       <= '0;
            start_reg     <= '0;
            done_reg      <= 1'b0;
            wptr_reg      <= '0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            mismatch_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            done_reg      <= done_next;
            wptr_reg      <= wptr_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            mismatch_reg  <= mismatch_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        base_reg      <= base_next;
        last_reg      <= last_next;
        res_found_reg <= res_found_next;
        res_index_reg <= res_index_next;
        if (cmd.load_out) begin
            m_found_reg    <= res_found_reg;
            m_index_reg    <= res_found_reg ? res_index_reg : '0;
            m_overflow_reg <= overflow_reg;
        end
    end

    // Pattern memory: append write, registered compare read.
    always_ff @(posedge aclk) begin
        if (is_append && room) begin
            pattern_mem[count_reg[PAW-1:0]] <= s_byte_value;
        end
        if (issue) begin
            pat_rd_reg <= pattern_mem[idx_reg[PAW-1:0]];
        end
    end

    // Window memory: newest byte at the write pointer, read from the match start.
    always_ff @(posedge aclk) begin
        if (is_text && in_range) begin
            window_mem[wptr_reg] <= s_byte_value;
        end
        if (issue) begin
            win_rd_reg <= window_mem[base_reg + idx_reg[WAW-1:0]];
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_found            = m_found_reg;
    assign m_match_index      = m_index_reg;
    assign m_pattern_overflow = m_overflow_reg;

endmodule

>>> verif/tb_substring_first_match_search.sv
`timescale 1ns / 1ps

module tb_substring_first_match_search;
    import sfms_pkg::*;

    localparam int PATTERN_MAX   = 64;
    localparam int TEXT_MAX      = 65536;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 60;
    localparam int IDLE_PERCENT  = 21;

    // Kind code that the block has to ignore.
    localparam kind_t KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] offset;
        logic               overflow;
    } match_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  value;
        logic               last;
        logic [INDEX_W-1:0] start;
        int                 reps;
        logic               typed;
        match_t             want;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic [7:0]         s_byte_value;
    logic               s_last;
    logic [15:0]        s_start_index;
    logic               m_valid;
    logic               m_ready;
    logic               m_found;
    logic [15:0]        m_match_index;
    logic               m_pattern_overflow;

    // Own copy of the search state.
    logic [BYTE_W-1:0]  pat_mem [PATTERN_MAX];
    int                 pat_len = 0;
    logic [BYTE_W-1:0]  text_win [PATTERN_MAX];
    int                 text_pos = 0;
    int                 search_from = 0;
    bit                 hit_reported = 1'b0;
    bit                 pat_overflow = 1'b0;

    match_t             pending_matches [$];
    match_t             oldest;
    int                 mismatches = 0;
    int                 results_seen = 0;
    int                 items_sent = 0;
    int                 quiet_cycles = 0;
    bit                 steady = 1'b0;

    // Directed transactions; an expected result is typed in only where it is obvious.
    stim_row_t dir_rows [0:24] = '{
        '{KIND_TEXT,   8'h00, 1'b1, 16'hFFFF,  1, 1'b1, '{1'b1, 16'd0, 1'b0}},
        '{KIND_UNUSED, 8'hFF, 1'b1, 16'hFFFF,  1, 1'b0, '0},
        '{KIND_APPEND, 8'hFF, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_APPEND, 8'h00, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'h00, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'hFF, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'h00, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'hFF, 1'b1, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'h12, 1'b1, 16'h0000,  1, 1'b1, '{1'b0, 16'd0, 1'b0}},
        '{KIND_CLEAR,  8'h00, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_APPEND, 8'hA5, 1'b0, 16'h0000, 65, 1'b0, '0},
        '{KIND_TEXT,   8'hA5, 1'b0, 16'h0000, 63, 1'b0, '0},
        '{KIND_TEXT,   8'hA5, 1'b1, 16'h0000,  1, 1'b1, '{1'b1, 16'd0, 1'b1}},
        '{KIND_CLEAR,  8'h00, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_APPEND, 8'h41, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'h41, 1'b0, 16'h0002,  1, 1'b0, '0},
        '{KIND_APPEND, 8'h42, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'h41, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'h42, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'h41, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'h42, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'h00, 1'b1, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'h41, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_CLEAR,  8'h00, 1'b0, 16'h0000,  1, 1'b0, '0},
        '{KIND_TEXT,   8'h42, 1'b1, 16'h0000,  1, 1'b0, '0}
    };

    substring_first_match_search #(
        .PATTERN_MAX(PATTERN_MAX),
        .TEXT_MAX(TEXT_MAX)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_byte_value(s_byte_value),
        .s_last(s_last),
        .s_start_index(s_start_index),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_found(m_found),
        .m_match_index(m_match_index),
        .m_pattern_overflow(m_pattern_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // True when the newest bytes of the window spell the whole stored pattern.
    function automatic bit window_holds_pattern();
        int j;
        for (j = 0; j < pat_len; j++) begin
            if (text_win[pat_len - 1 - j] != pat_mem[j]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advances the search state by one transaction and returns 1 when it yields a result.
    function automatic bit search_step(input kind_t kind, input logic [BYTE_W-1:0] value,
                                       input logic last, input logic [INDEX_W-1:0] start,
                                       output match_t res);
        bit yields;
        int i;
        int match_start;
        yields = 1'b0;
        res = '0;
        case (kind)
            KIND_APPEND: begin
                if (pat_len < PATTERN_MAX) begin
                    pat_mem[pat_len] = value;
                    pat_len++;
                end else begin
                    pat_overflow = 1'b1;
                end
            end
            KIND_CLEAR: begin
                pat_len = 0;
                pat_overflow = 1'b0;
            end
            KIND_TEXT: begin
                if (text_pos == 0) search_from = start;
                // Bytes past the end of the addressable text are not compared.
                if (text_pos < TEXT_MAX) begin
                    for (i = PATTERN_MAX - 1; i > 0; i--) text_win[i] = text_win[i - 1];
                    text_win[0] = value;
                    text_pos++;
                    if (!hit_reported) begin
                        if (pat_len == 0) begin
                            yields = (text_pos == 1);
                            match_start = 0;
                        end else if (text_pos >= pat_len) begin
                            match_start = text_pos - pat_len;
                            yields = (match_start >= search_from) && window_holds_pattern();
                        end
                        if (yields) begin
                            res = '{1'b1, INDEX_W'(match_start), pat_overflow};
                            hit_reported = 1'b1;
                        end
                    end
                end
                // The last byte reports a miss if nothing was found and clears the search for the next text.
                if (last) begin
                    if (!hit_reported && !yields) begin
                        res = '{1'b0, '0, pat_overflow};
                        yields = 1'b1;
                    end
                    text_pos = 0;
                    search_from = 0;
                    hit_reported = 1'b0;
                    for (i = 0; i < PATTERN_MAX; i++) text_win[i] = '0;
                end
            end
            default: ;
        endcase
        return yields;
    endfunction

    // Offers one transaction, after a random gap unless steady is set, and records any expected result.
    task automatic offer(input kind_t kind, input logic [BYTE_W-1:0] value,
                         input logic last, input logic [INDEX_W-1:0] start,
                         input logic typed = 1'b0, input match_t want = '0);
        match_t got;
        bit yields;
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_byte_value  <= value;
        s_last        <= last;
        s_start_index <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        yields = search_step(kind, value, last, start, got);
        if (yields) pending_matches.push_back(typed ? want : got);
        if (kind != KIND_UNUSED) items_sent++;
        @(negedge aclk);
    endtask

    // Holds the input idle until every outstanding result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_matches.size() != 0) @(negedge aclk);
    endtask

    // One search: optional clear, a pattern, then text over a small alphabet,
    // with stray transactions mixed in now and then.
    task automatic run_job();
        int plen;
        int tlen;
        int asz;
        int r;
        int i;
        bit broken;
        logic [BYTE_W-1:0] alph [0:3];
        logic [INDEX_W-1:0] start;
        for (i = 0; i < 4; i++) alph[i] = 8'($urandom);
        asz = $urandom_range(1, 3);
        broken = ($urandom_range(0, 99) < 4);
        if ($urandom_range(0, 99) < 70)
            offer(KIND_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)), 16'($urandom));
        r = $urandom_range(0, 99);
        if (r < 8) plen = 0;
        else if (r < 12) plen = $urandom_range(PATTERN_MAX - 4, PATTERN_MAX + 6);
        else plen = $urandom_range(1, 5);
        for (i = 0; i < plen; i++)
            offer(KIND_APPEND, alph[$urandom_range(0, asz - 1)],
                  1'($urandom_range(0, 1)), 16'($urandom));
        tlen = (plen > 20) ? plen + $urandom_range(0, 8) : $urandom_range(1, 24);
        r = $urandom_range(0, 99);
        if (r < 70) start = 16'($urandom_range(0, tlen));
        else if (r < 85) start = '0;
        else start = 16'($urandom);
        for (i = 0; i < tlen; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                offer(KIND_UNUSED, 8'($urandom), 1'($urandom_range(0, 1)), 16'($urandom));
            else if (r < 5)
                offer(KIND_APPEND, alph[$urandom_range(0, asz - 1)], 1'b0, 16'($urandom));
            else if (r < 6)
                offer(KIND_CLEAR, 8'($urandom), 1'b0, 16'($urandom));
            // Only the first text byte carries the start position that counts.
            offer(KIND_TEXT, alph[$urandom_range(0, asz - 1)],
                  (i == tlen - 1) && !broken, (i == 0) ? start : 16'($urandom));
        end
    endtask

    // Result side: random stalls, plus one long hold-off that backs up the block.
    initial begin
        bit held;
        held = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Result checking and the watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_matches.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result found=%0d match_index=%0d overflow=%0d",
                             $time, m_found, m_match_index, m_pattern_overflow);
                end else begin
                    oldest = pending_matches.pop_front();
                    if (m_found !== oldest.found) begin
                        mismatches++;
                        $display("%0t: found expected %0d, actual %0d",
                                 $time, oldest.found, m_found);
                    end
                    if (m_match_index !== oldest.offset) begin
                        mismatches++;
                        $display("%0t: match_index expected %0d, actual %0d",
                                 $time, oldest.offset, m_match_index);
                    end
                    if (m_pattern_overflow !== oldest.overflow) begin
                        mismatches++;
                        $display("%0t: pattern_overflow expected %0d, actual %0d",
                                 $time, oldest.overflow, m_pattern_overflow);
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed table, then random searches.
    initial begin
        int r;
        int k;
        int jobs;
        int random_base;
        s_valid       = 1'b0;
        s_kind        = KIND_APPEND;
        s_byte_value  = '0;
        s_last        = 1'b0;
        s_start_index = '0;
        aresetn       = 1'b0;
        for (k = 0; k < PATTERN_MAX; k++) begin
            pat_mem[k]  = '0;
            text_win[k] = '0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < $size(dir_rows); r++) begin
            for (k = 0; k < dir_rows[r].reps; k++)
                offer(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].last,
                      dir_rows[r].start, dir_rows[r].typed, dir_rows[r].want);
        end

        drain_results();

        jobs = 0;
        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            jobs++;
            if (jobs % 40 == 0) drain_results();
            steady = (items_sent - random_base >= 700) && (items_sent - random_base < 1000);
            run_job();
        end
        steady = 1'b0;

        s_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_matches.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> substring_first_match_search.f
hw/rtl/sfms_pkg.sv
hw/rtl/sfms_ctrl.sv
hw/rtl/sfms_dp.sv
hw/rtl/substring_first_match_search.sv
verif/tb_substring_first_match_search.sv
